// File: sv/mf2d_pkg.sv
package mf2d_pkg;

	// fixed field widths
	localparam int PIX_W = 8;
	localparam int COL_W = 11;
	localparam int ROW_W = 16;
	localparam int SEQ_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_WIDTH_MAX = 2047;
	localparam int JQ_DEPTH = 4;

	// request opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// register indexes
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [COL_W-1:0] WIDTH_RESET = 11'd1024;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd1024;

	typedef struct packed {
		logic op;
		logic [PIX_W-1:0] pixel_in;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic frame_end;
	} out_item_t;

	// one output position handed from front to back
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] wm1;
		logic [ROW_W-1:0] hm1;
		logic [SEQ_W-1:0] seq;
		logic last;
	} job_t;

	// row store write
	typedef struct packed {
		logic en;
		logic [COL_W-1:0] col;
		logic [SEQ_W-1:0] seq;
		logic [PIX_W-1:0] pix;
	} wr_t;

	// back has finished reading rows of a job
	typedef struct packed {
		logic valid;
		logic [SEQ_W-1:0] seq;
	} retire_t;

endpackage

// File: sv/median_filter_2d.sv
// channel   dir   handshake            payload
// in_item   in    push / full          op, pixel_in
// out_item  out   pop / empty          pixel_out, frame_end
// cfg       in    cfg_write            cfg_index, cfg_data
//
// One pixel per clock is taken while full is low; at the start of each output row
// the back primes the window with R+1 column fetches, the last giving the first result.
// Results trail by about R rows plus the fetch, bank read and sort pipeline stages.
// full rises while the job queue is full or the row bank the next row reuses
// is still being read. Reset is asynchronous and leaves the row banks as is.
module median_filter_2d #(
	parameter int WINDOW = 5,
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic cfg_index,
	input logic [mf2d_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic push,
	output logic full,
	input mf2d_pkg::in_item_t in_item,
	output logic empty,
	input logic pop,
	output mf2d_pkg::out_item_t out_item
);
	import mf2d_pkg::*;

	localparam int TAPS = WINDOW * WINDOW;

	logic jq_full, job_push, job_valid, job_pop, en;
	job_t job_in, job_head;
	wr_t wr;
	retire_t retire;
	logic med_in_valid, med_in_last, med_valid, med_last;
	logic [TAPS*PIX_W-1:0] med_taps;
	logic [PIX_W-1:0] med_pix;

	out_item_t oq_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic oq_push, oq_pop;

	mf2d_front #(.WINDOW(WINDOW), .MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .in_item(in_item), .full(full),
		.jq_full(jq_full), .retire(retire),
		.job_push(job_push), .job(job_in), .wr(wr)
	);

	mf2d_jobq u_jobq (
		.clk(clk), .arst_n(arst_n),
		.wr_en(job_push), .wr_job(job_in), .q_full(jq_full),
		.rd_en(job_pop), .rd_valid(job_valid), .rd_job(job_head)
	);

	mf2d_back #(.WINDOW(WINDOW), .MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .wr(wr),
		.job_valid(job_valid), .job(job_head), .job_pop(job_pop),
		.retire(retire),
		.med_valid(med_in_valid), .med_last(med_in_last), .med_taps(med_taps)
	);

	mf2d_median #(.WINDOW(WINDOW)) u_median (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(med_in_valid), .in_last(med_in_last), .in_taps(med_taps),
		.out_valid(med_valid), .out_last(med_last), .out_pix(med_pix)
	);

	// back pipeline advances while the result buffer has room
	assign en = cnt_q != 2'd2;
	assign oq_push = en && med_valid;
	assign oq_pop = pop && !empty;
	assign empty = cnt_q == 2'd0;
	assign out_item = oq_q[rp_q];

	// two-entry result buffer
	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[wp_q] <= '{pixel_out: med_pix, frame_end: med_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (oq_push) begin
				wp_q <= !wp_q;
			end
			if (oq_pop) begin
				rp_q <= !rp_q;
			end
			if (oq_push && !oq_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!oq_push && oq_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/mf2d_jobq.sv
module mf2d_jobq (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input mf2d_pkg::job_t wr_job,
	output logic q_full,
	input logic rd_en,
	output logic rd_valid,
	output mf2d_pkg::job_t rd_job
);
	import mf2d_pkg::*;

	localparam int PW = $clog2(JQ_DEPTH);

	job_t slot_q [JQ_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0] cnt_q;

	assign q_full = cnt_q == (PW+1)'(JQ_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_job = slot_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wp_q] <= wr_job;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/mf2d_front.sv
module mf2d_front #(
	parameter int WINDOW = 5,
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic cfg_index,
	input logic [mf2d_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic push,
	input mf2d_pkg::in_item_t in_item,
	output logic full,
	input logic jq_full,
	input mf2d_pkg::retire_t retire,
	output logic job_push,
	output mf2d_pkg::job_t job,
	output mf2d_pkg::wr_t wr
);
	import mf2d_pkg::*;

	localparam int RADIUS = WINDOW / 2;
	localparam int NBANK = 2 ** $clog2(3 * RADIUS + 3);
	localparam int TH_W = $clog2(RADIUS * CFG_WIDTH_MAX + RADIUS + 2);
	localparam int MAXW_I = (MAX_WIDTH > CFG_WIDTH_MAX) ? CFG_WIDTH_MAX : MAX_WIDTH;
	localparam logic [COL_W-1:0] MAXW = COL_W'(MAXW_I);

	logic [COL_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [COL_W-1:0] w_q;
	logic [ROW_W-1:0] h_q;
	logic [TH_W-1:0] th_q;
	logic busy_q;
	logic [COL_W-1:0] icol_q;
	logic [ROW_W-1:0] irow_q;
	logic [TH_W-1:0] d_q;
	logic [COL_W-1:0] ocol_q;
	logic [ROW_W-1:0] orow_q;
	logic [SEQ_W-1:0] oseq_q;
	logic [SEQ_W-1:0] fseq_q;
	logic [SEQ_W-1:0] lr_q;

	logic [COL_W-1:0] eff_w, cur_w;
	logic [ROW_W-1:0] eff_h, cur_h;
	logic [TH_W-1:0] eff_th, cur_th, d_new;
	logic accept, is_pix, start, all_in, wr_pix, col_wrap, all_in_new, emit;
	logic o_wrap, o_last, block;
	logic [SEQ_W-1:0] seq_gap;

	// frame sizes taken from the registers
	always_comb begin
		if (width_q == '0) begin
			eff_w = COL_W'(1);
		end else if (width_q > MAXW) begin
			eff_w = MAXW;
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q == '0) ? ROW_W'(1) : height_q;
		eff_th = TH_W'(RADIUS) * TH_W'(eff_w) + TH_W'(RADIUS + 1);
	end

	// item classification and emission decision
	always_comb begin
		accept = push && !full;
		is_pix = in_item.op == OP_PIXEL;
		start = accept && is_pix && !busy_q;
		cur_w = start ? eff_w : w_q;
		cur_h = start ? eff_h : h_q;
		cur_th = start ? eff_th : th_q;
		all_in = irow_q == cur_h;
		wr_pix = accept && is_pix && !all_in;
		col_wrap = icol_q == cur_w - 1'b1;
		d_new = d_q + TH_W'(wr_pix);
		all_in_new = all_in ||
			(wr_pix && col_wrap && ((ROW_W+1)'(irow_q) + 1'b1 == (ROW_W+1)'(cur_h)));
		emit = accept && (busy_q || start) && (d_new >= cur_th || all_in_new);
		o_wrap = ocol_q == cur_w - 1'b1;
		o_last = o_wrap && (orow_q == cur_h - 1'b1);
	end

	// hold off while the back still needs the bank that the next row reuses
	assign seq_gap = fseq_q - lr_q;
	assign block = seq_gap >= SEQ_W'(NBANK - RADIUS);
	assign full = jq_full || block;

	always_comb begin
		job_push = emit;
		job.col = ocol_q;
		job.row = orow_q;
		job.wm1 = cur_w - 1'b1;
		job.hm1 = cur_h - 1'b1;
		job.seq = oseq_q;
		job.last = o_last;
		wr.en = wr_pix;
		wr.col = icol_q;
		wr.seq = fseq_q;
		wr.pix = in_item.pixel_in;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[COL_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[ROW_W-1:0];
				end
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	// frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WIDTH_RESET;
			h_q <= HEIGHT_RESET;
			th_q <= '0;
			busy_q <= 1'b0;
			icol_q <= '0;
			irow_q <= '0;
			d_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			oseq_q <= '0;
			fseq_q <= '0;
			lr_q <= '0;
		end else begin
			if (retire.valid) begin
				lr_q <= retire.seq;
			end
			if (start) begin
				w_q <= eff_w;
				h_q <= eff_h;
				th_q <= eff_th;
				busy_q <= 1'b1;
			end
			if (wr_pix) begin
				if (col_wrap) begin
					icol_q <= '0;
					irow_q <= irow_q + 1'b1;
					fseq_q <= fseq_q + 1'b1;
				end else begin
					icol_q <= icol_q + 1'b1;
				end
			end
			if (accept) begin
				d_q <= emit ? d_new - 1'b1 : d_new;
			end
			if (emit) begin
				if (o_wrap) begin
					ocol_q <= '0;
					orow_q <= orow_q + 1'b1;
					oseq_q <= oseq_q + 1'b1;
				end else begin
					ocol_q <= ocol_q + 1'b1;
				end
				if (o_last) begin
					icol_q <= '0;
					irow_q <= '0;
					d_q <= '0;
					ocol_q <= '0;
					orow_q <= '0;
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: sv/mf2d_back.sv
module mf2d_back #(
	parameter int WINDOW = 5,
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input mf2d_pkg::wr_t wr,
	input logic job_valid,
	input mf2d_pkg::job_t job,
	output logic job_pop,
	output mf2d_pkg::retire_t retire,
	output logic med_valid,
	output logic med_last,
	output logic [WINDOW*WINDOW*mf2d_pkg::PIX_W-1:0] med_taps
);
	import mf2d_pkg::*;

	localparam int RADIUS = WINDOW / 2;
	localparam int NBANK = 2 ** $clog2(3 * RADIUS + 3);
	localparam int BW = $clog2(NBANK);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int KW = $clog2(RADIUS + 1);

	logic [KW-1:0] k_q;
	logic prime, fin, fill;
	logic [COL_W:0] want;
	logic [COL_W-1:0] c;
	logic [BW-1:0] sel [WINDOW];

	logic v_s1, fill_s1, fin_s1, last_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic [BW-1:0] sel_s1 [WINDOW];
	logic [AW-1:0] addr_s1;

	logic [PIX_W-1:0] rd_q [NBANK];

	logic v_s2, fill_s2, fin_s2, last_s2;
	logic [BW-1:0] sel_s2 [WINDOW];

	logic [PIX_W-1:0] col_pix [WINDOW];
	logic [PIX_W-1:0] win_q [WINDOW][WINDOW];
	logic [PIX_W-1:0] win_next [WINDOW][WINDOW];

	// column to fetch for the job at the head; a row start primes R+1 columns
	always_comb begin
		prime = job.col == '0;
		want = prime ? (COL_W+1)'(k_q) : (COL_W+1)'(job.col) + (COL_W+1)'(RADIUS);
		c = (want > (COL_W+1)'(job.wm1)) ? job.wm1 : want[COL_W-1:0];
		fin = !prime || (k_q == KW'(RADIUS));
		fill = prime && (k_q == '0);
		job_pop = en && job_valid && fin;
	end

	// bank of each window row, rows clamped to the frame
	for (genvar j = 0; j < WINDOW; j++) begin : g_sel
		logic [ROW_W:0] t;
		logic [ROW_W:0] r;
		always_comb begin
			t = (ROW_W+1)'(job.row) + (ROW_W+1)'(j);
			r = (t < (ROW_W+1)'(RADIUS)) ? '0 : t - (ROW_W+1)'(RADIUS);
			if (r > (ROW_W+1)'(job.hm1)) begin
				r = (ROW_W+1)'(job.hm1);
			end
			sel[j] = job.seq[BW-1:0] - job.row[BW-1:0] + r[BW-1:0];
		end
	end

	// priming step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (en && job_valid) begin
			k_q <= fin ? '0 : k_q + 1'b1;
		end
	end

	// fetch stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fill_s1 <= fill;
			fin_s1 <= fin;
			last_s1 <= job.last;
			seq_s1 <= job.seq;
			addr_s1 <= AW'(c);
			sel_s1 <= sel;
			fill_s2 <= fill_s1;
			fin_s2 <= fin_s1;
			last_s2 <= last_s1;
			sel_s2 <= sel_s1;
		end
	end

	assign retire.valid = en && v_s1 && fin_s1;
	assign retire.seq = seq_s1;

	// row banks, one image row each
	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		logic [PIX_W-1:0] mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (wr.en && (wr.seq[BW-1:0] == BW'(b))) begin
				mem[AW'(wr.col)] <= wr.pix;
			end
			if (en) begin
				rd_q[b] <= mem[addr_s1];
			end
		end
	end

	// column assembly and window shift
	always_comb begin
		for (int j = 0; j < WINDOW; j++) begin
			col_pix[j] = rd_q[sel_s2[j]];
		end
		for (int i = 0; i < WINDOW; i++) begin
			for (int j = 0; j < WINDOW; j++) begin
				if (fill_s2 || i == WINDOW - 1) begin
					win_next[i][j] = col_pix[j];
				end else begin
					win_next[i][j] = win_q[(i + 1) % WINDOW][j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			win_q <= win_next;
		end
	end

	always_comb begin
		med_valid = v_s2 && fin_s2;
		med_last = last_s2;
		for (int i = 0; i < WINDOW; i++) begin
			for (int j = 0; j < WINDOW; j++) begin
				med_taps[(i*WINDOW+j)*PIX_W +: PIX_W] = win_next[i][j];
			end
		end
	end

endmodule

// File: sv/mf2d_median.sv
module mf2d_median #(
	parameter int WINDOW = 5
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic in_last,
	input logic [WINDOW*WINDOW*mf2d_pkg::PIX_W-1:0] in_taps,
	output logic out_valid,
	output logic out_last,
	output logic [mf2d_pkg::PIX_W-1:0] out_pix
);
	import mf2d_pkg::*;

	localparam int TAPS = WINDOW * WINDOW;

	logic [PIX_W-1:0] st_q [TAPS][TAPS];
	logic [TAPS-1:0] v_q;
	logic [TAPS-1:0] l_q;

	// odd-even transposition sort, one round per stage
	for (genvar s = 0; s < TAPS; s++) begin : g_stage
		logic [PIX_W-1:0] cur [TAPS];
		logic [PIX_W-1:0] nx [TAPS];
		if (s == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < TAPS; i++) begin
					cur[i] = in_taps[i*PIX_W +: PIX_W];
				end
			end
		end else begin : g_rest
			assign cur = st_q[s-1];
		end
		always_comb begin
			nx = cur;
			for (int i = s % 2; i + 1 < TAPS; i += 2) begin
				if (cur[i] > cur[i+1]) begin
					nx[i] = cur[i+1];
					nx[i+1] = cur[i];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_q[s] <= nx;
			end
		end
	end

	// valid and frame end travel alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			l_q <= '0;
		end else if (en) begin
			v_q <= {v_q[TAPS-2:0], in_valid};
			l_q <= {l_q[TAPS-2:0], in_last};
		end
	end

	assign out_valid = v_q[TAPS-1];
	assign out_last = l_q[TAPS-1];
	assign out_pix = st_q[TAPS-1][TAPS/2];

endmodule
